// ----- design/operating_mode_priority_arbiter_unit_defines.svh -----
// ---------------------------------------------------------------------------
// Operating mode priority arbiter assertion macros
// Shared concurrent assertion forms that can be compiled out as a group.
// ---------------------------------------------------------------------------
`ifndef OPERATING_MODE_PRIORITY_ARBITER_UNIT_DEFINES_SVH
`define OPERATING_MODE_PRIORITY_ARBITER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define OMP_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define OMP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define OMP_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define OMP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- design/omp_pkg.sv -----
// ---------------------------------------------------------------------------
// Operating mode priority arbiter package
// Types, priority tables and codes shared by the arbiter modules.
// ---------------------------------------------------------------------------
package omp_pkg;

  localparam int DEF_NUM_CLIENTS = 8;
  localparam int MASK_W          = 16;
  localparam int MODE_W          = 12;
  localparam int INDEX_W         = 8;
  localparam int NUM_PRIO        = 10;

  typedef logic [MASK_W-1:0] mask_t;
  typedef logic [MODE_W-1:0] mode_t;

  localparam mask_t KEEP_BITS    = 16'h0060;
  localparam mask_t REFUSE_BIT   = 16'h0040;
  localparam mask_t REFUSE_BLOCK = 16'h0208;
  localparam mode_t RESET_MODE   = 12'h100;
  localparam mask_t RESET_MERGED = 16'h0100;

  localparam logic [1:0] EXTRA_NONE   = 2'd0;
  localparam logic [1:0] EXTRA_MODE40 = 2'd1;
  localparam logic [1:0] EXTRA_LATCH  = 2'd2;
  localparam logic [1:0] EXTRA_CLEAR  = 2'd3;

  localparam mode_t PRIO_BIT [NUM_PRIO] = '{
    12'h100, 12'h400, 12'h200, 12'h080, 12'h040,
    12'h800, 12'h008, 12'h004, 12'h002, 12'h001
  };
  localparam logic PRIO_HIGH [NUM_PRIO] = '{
    1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1
  };
  localparam logic [1:0] PRIO_EXTRA [NUM_PRIO] = '{
    EXTRA_NONE, EXTRA_NONE, EXTRA_NONE, EXTRA_NONE, EXTRA_MODE40,
    EXTRA_NONE, EXTRA_NONE, EXTRA_NONE, EXTRA_LATCH, EXTRA_CLEAR
  };

  typedef struct packed {
    logic       found;
    logic       refused;
    logic       fired;
    logic       high_args;
    logic [1:0] extra_action;
    mode_t      mode;
  } sel_t;

endpackage

// ----- design/omp_client_store.sv -----
// ---------------------------------------------------------------------------
// Operating mode client store
// Holds one request mask per client and merges them with the incoming word.
// ---------------------------------------------------------------------------
module omp_client_store #(
  parameter int NUM_CLIENTS = omp_pkg::DEF_NUM_CLIENTS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [omp_pkg::INDEX_W-1:0] client_index,
  input  omp_pkg::mask_t              new_mask,
  input  logic                        wr_en,
  input  omp_pkg::mask_t              wr_data,
  output logic                        in_range,
  output omp_pkg::mask_t              merged_or
);
  import omp_pkg::*;

  localparam int IDX_W = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;

  mask_t            clients_r [NUM_CLIENTS];
  logic [IDX_W-1:0] slot;

  assign slot     = client_index[IDX_W-1:0];
  assign in_range = ({1'b0, client_index} < (INDEX_W + 1)'(NUM_CLIENTS));

  always_comb begin
    merged_or = '0;
    for (int i = 0; i < NUM_CLIENTS; i++) begin
      if (in_range && (slot == IDX_W'(i))) begin
        merged_or = merged_or | new_mask;
      end else begin
        merged_or = merged_or | clients_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CLIENTS; i++) begin
        clients_r[i] <= '0;
      end
    end else if (wr_en && in_range) begin
      clients_r[slot] <= wr_data;
    end
  end

endmodule

// ----- design/omp_mode_select.sv -----
// ---------------------------------------------------------------------------
// Operating mode selector
// Fixed priority pick over the merged mask with refusal and event detection.
// ---------------------------------------------------------------------------
module omp_mode_select (
  input  omp_pkg::mask_t cur_mask,
  input  omp_pkg::mask_t prev_mask,
  output omp_pkg::sel_t  sel
);
  import omp_pkg::*;

  logic dropped;

  always_comb begin
    sel     = '0;
    dropped = 1'b0;
    for (int i = 0; i < NUM_PRIO; i++) begin
      if (!sel.found) begin
        if ((cur_mask[MODE_W-1:0] & PRIO_BIT[i]) != '0) begin
          if ((PRIO_BIT[i] == REFUSE_BIT[MODE_W-1:0]) && ((cur_mask & REFUSE_BLOCK) != '0)) begin
            sel.refused = 1'b1;
          end else begin
            sel.found = 1'b1;
            sel.mode  = PRIO_BIT[i];
            if ((i != 0) && (((prev_mask[MODE_W-1:0] & PRIO_BIT[i]) == '0) || dropped)) begin
              sel.fired        = 1'b1;
              sel.high_args    = PRIO_HIGH[i];
              sel.extra_action = PRIO_EXTRA[i];
            end
          end
        end else if ((prev_mask[MODE_W-1:0] & PRIO_BIT[i]) != '0) begin
          dropped = 1'b1;
        end
      end
    end
  end

endmodule

// ----- design/operating_mode_priority_arbiter_unit.sv -----
// An accepted word is registered in the input register, and its result word in the result register.
// Throughput: one word per cycle while the output is not stalled; the mask merge and priority chain sit in one stage.
// Reset: synchronous, active low; client masks clear, merged mask and mode load 0x100.
// A stalled output holds the result register, and the input register while it holds a word.
// ---------------------------------------------------------------------------
// Operating mode priority arbiter
// Registers each client request word, merges all client masks and picks the
// active operating mode by fixed priority, reporting mode entry events.
// ---------------------------------------------------------------------------
`include "operating_mode_priority_arbiter_unit_defines.svh"

module operating_mode_priority_arbiter_unit #(
  parameter int NUM_CLIENTS = omp_pkg::DEF_NUM_CLIENTS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // new_mask [15:0], client_index [23:16]
  input  logic [23:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // active_mode [11:0], combined_mask [27:12], transition_fired [28],
  // high_args [29], extra_action [31:30]
  output logic [31:0] out_tdata
);
  import omp_pkg::*;

  logic                 s1_valid_r;
  mask_t                s1_mask_r;
  logic [INDEX_W-1:0]   s1_idx_r;
  logic                 out_valid_r;
  logic [31:0]          out_data_r;
  mask_t                merged_r;
  mode_t                current_r;
  logic                 adv;
  logic                 step;
  logic                 in_range;
  mask_t                merged_or;
  mask_t                cur_mask;
  mask_t                wr_data;
  mask_t                combined;
  mode_t                mode_nxt;
  sel_t                 sel;

  assign adv       = !out_valid_r || out_tready;
  assign step      = s1_valid_r && adv;
  assign in_tready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_mask_r <= in_tdata[15:0];
      s1_idx_r  <= in_tdata[23:16];
    end
  end

  omp_client_store #(
    .NUM_CLIENTS(NUM_CLIENTS)
  ) u_store (
    .clk         (clk),
    .rst_n       (rst_n),
    .client_index(s1_idx_r),
    .new_mask    (s1_mask_r),
    .wr_en       (step),
    .wr_data     (wr_data),
    .in_range    (in_range),
    .merged_or   (merged_or)
  );

  assign cur_mask = (merged_r & KEEP_BITS) | merged_or;

  omp_mode_select u_select (
    .cur_mask (cur_mask),
    .prev_mask(merged_r),
    .sel      (sel)
  );

  assign wr_data  = sel.refused ? (s1_mask_r & ~REFUSE_BIT) : s1_mask_r;
  assign combined = sel.refused ? (cur_mask & ~REFUSE_BIT) : cur_mask;
  assign mode_nxt = sel.found ? sel.mode : current_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      merged_r  <= RESET_MERGED;
      current_r <= RESET_MODE;
    end else if (step) begin
      merged_r  <= combined;
      current_r <= mode_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= {sel.extra_action, sel.high_args, sel.fired, combined, mode_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `OMP_ASSERT_SAME(a_mode_onehot, clk, rst_n, 1'b1, $onehot(current_r), "active mode is not one-hot")
  `OMP_ASSERT_SAME(a_quiet_args, clk, rst_n, out_tvalid && !out_tdata[28], out_tdata[31:29] == 3'b000, "event arguments set without an event")
  `OMP_ASSERT_SAME(a_no_base_event, clk, rst_n, out_tvalid && out_tdata[28], out_tdata[11:0] != RESET_MODE, "base mode reported an entry event")
  `OMP_ASSERT_NEXT(a_hold_stage, clk, rst_n, s1_valid_r && !adv, s1_valid_r && $stable(s1_mask_r) && $stable(s1_idx_r), "input stage lost a word under stall")

endmodule
